// ===== rtl/bles_pkg.sv =====
// shared types and constants for the brace list element splitter
package bles_pkg;

   localparam int BYTE_W        = 8;
   localparam int KIND_W        = 4;
   localparam int DEPTH_OUT_W   = 8;
   localparam int MAX_DEPTH_DEF = 255;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h5C;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_INSIDE = 2'd1,
      MODE_ERROR  = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SKIP     = 4'd0,
      KIND_OPEN     = 4'd1,
      KIND_CONTENT  = 4'd2,
      KIND_CLOSE    = 4'd3,
      KIND_STRAY    = 4'd4,
      KIND_UNCLOSED = 4'd5,
      KIND_END      = 4'd6,
      KIND_DEEP     = 4'd7,
      KIND_IGNORED  = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [BYTE_W-1:0]        byte_out;
      logic [DEPTH_OUT_W-1:0]   nest_depth;
      logic                     element_flat;
   } rsp_type;

endpackage

// ===== rtl/bles_if.sv =====
// valid/ready channel interfaces for the input byte and the result word
interface bles_req_if;
   import bles_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface bles_rsp_if;
   import bles_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [BYTE_W-1:0]      byte_out;
   logic [DEPTH_OUT_W-1:0] nest_depth;
   logic                   element_flat;
   modport source (output valid, output kind, output byte_out, output nest_depth,
                   output element_flat, input ready);
   modport sink   (input valid, input kind, input byte_out, input nest_depth,
                   input element_flat, output ready);
endinterface

// ===== rtl/brace_list_element_splitter.sv =====
// top level of the brace list element splitter: byte register, scanner, result register
// Splits a zero-terminated byte string into top-level {...} elements, one result word
// per input byte. A byte is taken into the input register, decoded against the scanner
// state in one pass of short logic, and its word moves on into the result register once
// that register is empty or its word is being taken; a new byte is taken every cycle
// while the result side keeps draining. The input side stalls only when both registers
// hold a word and the result side is not ready. The
// scanner state (mode, depth counter, escape flag, flat flag) updates as a byte moves from
// the input register to the result register, so consecutive bytes see each other's effect
// with no bubble. The depth counter is sized by MAX_DEPTH; nest_depth shows its low 8 bits.
// A zero byte always returns the scanner to its reset state.
module brace_list_element_splitter #(
   parameter int MAX_DEPTH = bles_pkg::MAX_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   bles_req_if.sink   req,
   bles_rsp_if.source rsp
);
   import bles_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   // input register
   logic              byte_valid_ff;
   logic [BYTE_W-1:0] byte_ff;

   // scanner state
   mode_type           mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               esc_ff, esc_in;
   logic               flat_ff, flat_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic advance;    // input register moves into the result register
   logic take;       // byte accepted on the request side

   assign advance   = byte_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !byte_valid_ff || advance;
   assign take      = req.valid && req.ready;

   bles_step #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W)
   ) u_step (
      .byte_in  (byte_ff),
      .mode     (mode_ff),
      .depth    (depth_ff),
      .esc      (esc_ff),
      .flat     (flat_ff),
      .mode_in  (mode_in),
      .depth_in (depth_in),
      .esc_in   (esc_in),
      .flat_in  (flat_in),
      .rsp      (rsp_in)
   );

   // control and scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_SEARCH;
         depth_ff      <= '0;
         esc_ff        <= 1'b0;
         flat_ff       <= 1'b1;
      end else begin
         if (take) begin
            byte_valid_ff <= 1'b1;
         end else if (advance) begin
            byte_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            depth_ff     <= depth_in;
            esc_ff       <= esc_in;
            flat_ff      <= flat_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req.byte_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_ff.kind;
   assign rsp.byte_out     = rsp_ff.byte_out;
   assign rsp.nest_depth   = rsp_ff.nest_depth;
   assign rsp.element_flat = rsp_ff.element_flat;

   // flat flag only ever rides on a close word
   a_flat_only_on_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.element_flat) |-> (rsp_ff.kind == KIND_CLOSE))
      else $error("element_flat set on a word that is not a close");

   // inside an element the depth counter is never zero
   a_inside_depth: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_INSIDE) |-> (depth_ff != '0))
      else $error("inside an element with zero depth");

   // depth counter stays within the limit
   a_depth_limit: assert property (@(posedge clock) disable iff (reset)
      (depth_ff <= DEPTH_W'(MAX_DEPTH)))
      else $error("depth counter beyond MAX_DEPTH");

   // a terminator word reports depth zero and leaves the depth counter at zero and the escape flag clear
   a_term_resets: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && (rsp_ff.kind == KIND_END || rsp_ff.kind == KIND_UNCLOSED)
      |-> (rsp_ff.nest_depth == '0) && (depth_ff == '0) && !esc_ff)
      else $error("terminator did not return the scanner to reset");

endmodule

// ===== rtl/bles_step.sv =====
// per-byte scanner logic: next state and result word for one byte
module bles_step #(
   parameter int MAX_DEPTH = bles_pkg::MAX_DEPTH_DEF,
   parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
   input  logic [bles_pkg::BYTE_W-1:0] byte_in,
   input  bles_pkg::mode_type          mode,
   input  logic [DEPTH_W-1:0]          depth,
   input  logic                        esc,
   input  logic                        flat,
   output bles_pkg::mode_type          mode_in,
   output logic [DEPTH_W-1:0]          depth_in,
   output logic                        esc_in,
   output logic                        flat_in,
   output bles_pkg::rsp_type           rsp
);
   import bles_pkg::*;

   localparam int WIDE_W = (DEPTH_W > DEPTH_OUT_W) ? DEPTH_W : DEPTH_OUT_W;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

   logic [DEPTH_W-1:0] depth_dec;
   logic [WIDE_W-1:0]  depth_wide;
   logic               is_nul;
   logic               is_open;
   logic               is_close;
   logic               is_esc;

   assign is_nul    = (byte_in == CH_NUL);
   assign is_open   = (byte_in == CH_OPEN);
   assign is_close  = (byte_in == CH_CLOSE);
   assign is_esc    = (byte_in == CH_ESC);
   assign depth_dec = (depth != '0) ? depth - DEPTH_ONE : depth;

   // next state
   always_comb begin
      mode_in  = mode;
      depth_in = depth;
      esc_in   = esc;
      flat_in  = flat;
      if (is_nul) begin
         mode_in  = MODE_SEARCH;
         depth_in = '0;
         esc_in   = 1'b0;
         flat_in  = 1'b1;
      end else begin
         case (mode)
            MODE_SEARCH: begin
               if (esc) begin
                  esc_in = 1'b0;
               end else if (is_esc) begin
                  esc_in = 1'b1;
               end else if (is_open) begin
                  mode_in  = MODE_INSIDE;
                  depth_in = DEPTH_ONE;
                  flat_in  = 1'b1;
               end else if (is_close) begin
                  mode_in = MODE_ERROR;
               end
            end
            MODE_INSIDE: begin
               if (esc) begin
                  esc_in = 1'b0;
               end else if (is_esc) begin
                  esc_in = 1'b1;
               end else if (is_open) begin
                  if (depth >= DEPTH_MAX) begin
                     mode_in = MODE_ERROR;
                  end else begin
                     depth_in = depth + DEPTH_ONE;
                     flat_in  = 1'b0;
                  end
               end else if (is_close) begin
                  depth_in = depth_dec;
                  if (depth_dec == '0) begin
                     mode_in = MODE_SEARCH;
                     esc_in  = 1'b0;
                     flat_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign depth_wide = WIDE_W'(depth_in);

   // result word
   always_comb begin
      rsp.kind         = KIND_IGNORED;
      rsp.byte_out     = byte_in;
      rsp.nest_depth   = depth_wide[DEPTH_OUT_W-1:0];
      rsp.element_flat = 1'b0;
      if (is_nul) begin
         rsp.kind = (mode == MODE_INSIDE) ? KIND_UNCLOSED : KIND_END;
      end else begin
         case (mode)
            MODE_SEARCH: begin
               rsp.kind = KIND_SKIP;
               if (!esc && !is_esc) begin
                  if (is_open) begin
                     rsp.kind = KIND_OPEN;
                  end else if (is_close) begin
                     rsp.kind = KIND_STRAY;
                  end
               end
            end
            MODE_INSIDE: begin
               rsp.kind = KIND_CONTENT;
               if (!esc && !is_esc) begin
                  if (is_open && depth >= DEPTH_MAX) begin
                     rsp.kind = KIND_DEEP;
                  end else if (is_close && depth_dec == '0) begin
                     rsp.kind         = KIND_CLOSE;
                     rsp.element_flat = flat;
                  end
               end
            end
            default: rsp.kind = KIND_IGNORED;
         endcase
      end
   end

endmodule
